>>> src/svfenv_pkg.sv
// Shared types, step codes and constants of the state-variable filter with envelope.
`timescale 1ns / 1ps

package svfenv_pkg;

   // Default audio sample rate in hertz.
   localparam int SAMPLE_RATE_DEF = 48000;

   // Operation codes carried in the request tuser field.
   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_TRIGGER = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // Datapath step codes issued by the controller.
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_NONE = 5'd0;
   localparam logic [STEP_W-1:0] STEP_LOAD = 5'd1;
   localparam logic [STEP_W-1:0] STEP_TRIG = 5'd2;
   localparam logic [STEP_W-1:0] STEP_REL  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_ENV  = 5'd4;
   localparam logic [STEP_W-1:0] STEP_MOD  = 5'd5;
   localparam logic [STEP_W-1:0] STEP_FC   = 5'd6;
   localparam logic [STEP_W-1:0] STEP_PH   = 5'd7;
   localparam logic [STEP_W-1:0] STEP_Y    = 5'd8;
   localparam logic [STEP_W-1:0] STEP_Y2   = 5'd9;
   localparam logic [STEP_W-1:0] STEP_Y2S  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_TA   = 5'd11;
   localparam logic [STEP_W-1:0] STEP_TB   = 5'd12;
   localparam logic [STEP_W-1:0] STEP_TC   = 5'd13;
   localparam logic [STEP_W-1:0] STEP_TD   = 5'd14;
   localparam logic [STEP_W-1:0] STEP_SIN  = 5'd15;
   localparam logic [STEP_W-1:0] STEP_SF   = 5'd16;
   localparam logic [STEP_W-1:0] STEP_HP   = 5'd17;
   localparam logic [STEP_W-1:0] STEP_HPS  = 5'd18;
   localparam logic [STEP_W-1:0] STEP_BP   = 5'd19;
   localparam logic [STEP_W-1:0] STEP_BPS  = 5'd20;
   localparam logic [STEP_W-1:0] STEP_LP   = 5'd21;
   localparam logic [STEP_W-1:0] STEP_LPS  = 5'd22;

   // Sine polynomial: five Horner terms with their divisors and scaled reciprocals.
   localparam int TERMS  = 5;
   localparam int ITER_W = 3;
   localparam logic [6:0] TAYLOR_DIV [TERMS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [29:0] TAYLOR_RECIP [TERMS] = '{
      30'((64'd1 << 32) / 64'd110), 30'((64'd1 << 32) / 64'd72),
      30'((64'd1 << 32) / 64'd42), 30'((64'd1 << 32) / 64'd20),
      30'((64'd1 << 32) / 64'd6)};

   // Divider dividend and quotient width.
   localparam int DVD_W = 40;

   // Control from the controller to the datapath.
   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [ITER_W-1:0] iter;
   } svfenv_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_busy;
      logic out_busy;
   } svfenv_stat_type;

endpackage

>>> src/state_variable_filter_with_envelope_unit.sv
// Top level of the state-variable filter with a linear envelope on the cutoff.
`timescale 1ns / 1ps
//
//  Channel  Direction  Beat contents
//  req_     in         tdata: sample_in[23:0]; tuser: operation[1:0]
//  rsp_     out        tdata: sample_out[23:0]
//  csr_     in         write enable, index 0..7, data[23:0]
//
// A trigger or release beat gives no result.
// An audio beat runs two divides on the shared radix-4 divider (phase and
// resonance reciprocal) and the 20-step sine polynomial on the single shared
// multiplier; the resonance divide overlaps the polynomial.
// Reset is synchronous and active high and restores all but the per-sample registers.
// A waiting result holds the final step only; the next beat is taken once it is stored.

module state_variable_filter_with_envelope_unit #(
   parameter int SAMPLE_RATE = svfenv_pkg::SAMPLE_RATE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [23:0] sample_in
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [23:0] sample_out
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   svfenv_pkg::svfenv_cmd_type  cmd;
   svfenv_pkg::svfenv_stat_type stat;

   svfenv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   svfenv_dp #(
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .sample_in  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Results stay within plus or minus 4.0.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata) <= 24'sd4194304 &&
                      $signed(rsp_tdata) >= -24'sd4194304))
      else $error("result outside the saturation range");

   // An accepted audio beat occupies the block on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == svfenv_pkg::OP_SAMPLE) |=> !req_tready)
      else $error("audio beat did not start processing");

   // A new result only appears at the end of a sample in flight.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result produced without a sample in flight");

   // Control beats never hold the input side.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != svfenv_pkg::OP_SAMPLE) |=> req_tready)
      else $error("control beat stalled the input");

endmodule

>>> src/svfenv_div.sv
// Restoring unsigned divider that retires two quotient bits per cycle.
`timescale 1ns / 1ps

module svfenv_div #(
   parameter int DVS_W = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [svfenv_pkg::DVD_W-1:0]  dividend,
   input  logic [DVS_W-1:0]              divisor,
   output logic                          busy,
   output logic [svfenv_pkg::DVD_W-1:0]  quotient
);

   localparam int HALF  = svfenv_pkg::DVD_W / 2;
   localparam int CNT_W = $clog2(HALF + 1);

   logic                         busy_ff, busy_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [DVS_W-1:0]             rem_ff, rem_in;
   logic [DVS_W-1:0]             dvs_ff;
   logic [svfenv_pkg::DVD_W-1:0] work_ff, work_in;
   logic [DVS_W:0]               s1, s2;

   // One restoring step: returns the quotient bit over the new remainder.
   function automatic logic [DVS_W:0] div_bit(input logic [DVS_W-1:0] rem,
                                              input logic nb,
                                              input logic [DVS_W-1:0] d);
      logic [DVS_W:0] t;
      t = {rem, nb};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
         div_bit = {1'b1, t[DVS_W-1:0]};
      end else begin
         div_bit = {1'b0, t[DVS_W-1:0]};
      end
   endfunction

   // Two dependent steps per cycle; quotient bits shift in at the bottom.
   always_comb begin
      s1      = div_bit(rem_ff, work_ff[svfenv_pkg::DVD_W-1], dvs_ff);
      s2      = div_bit(s1[DVS_W-1:0], work_ff[svfenv_pkg::DVD_W-2], dvs_ff);
      rem_in  = s2[DVS_W-1:0];
      work_in = {work_ff[svfenv_pkg::DVD_W-3:0], s1[DVS_W], s2[DVS_W]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(HALF);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= '0;
         work_ff <= dividend;
         dvs_ff  <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         work_ff <= work_in;
      end
   end

   assign busy     = busy_ff;
   assign quotient = work_ff;

endmodule

>>> src/svfenv_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
`timescale 1ns / 1ps

module svfenv_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic [1:0]                  req_op,
   output logic                        req_tready,
   input  svfenv_pkg::svfenv_stat_type stat,
   output svfenv_pkg::svfenv_cmd_type  cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_ENV  = 5'd1;
   localparam logic [4:0] S_MOD  = 5'd2;
   localparam logic [4:0] S_FC   = 5'd3;
   localparam logic [4:0] S_PHW  = 5'd4;
   localparam logic [4:0] S_Y    = 5'd5;
   localparam logic [4:0] S_Y2   = 5'd6;
   localparam logic [4:0] S_Y2S  = 5'd7;
   localparam logic [4:0] S_TA   = 5'd8;
   localparam logic [4:0] S_TB   = 5'd9;
   localparam logic [4:0] S_TC   = 5'd10;
   localparam logic [4:0] S_TD   = 5'd11;
   localparam logic [4:0] S_SIN  = 5'd12;
   localparam logic [4:0] S_SF   = 5'd13;
   localparam logic [4:0] S_QW   = 5'd14;
   localparam logic [4:0] S_HPS  = 5'd15;
   localparam logic [4:0] S_BP   = 5'd16;
   localparam logic [4:0] S_BPS  = 5'd17;
   localparam logic [4:0] S_LP   = 5'd18;
   localparam logic [4:0] S_LPS  = 5'd19;

   localparam logic [svfenv_pkg::ITER_W-1:0] ITER_LAST =
      svfenv_pkg::ITER_W'(svfenv_pkg::TERMS - 1);

   logic [4:0]                    state_ff, state_in;
   logic [svfenv_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic [svfenv_pkg::STEP_W-1:0] step;

   // Next state and the step issued in the current state.
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      step     = svfenv_pkg::STEP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_op)
                  svfenv_pkg::OP_SAMPLE: begin
                     step     = svfenv_pkg::STEP_LOAD;
                     state_in = S_ENV;
                  end
                  svfenv_pkg::OP_TRIGGER: step = svfenv_pkg::STEP_TRIG;
                  svfenv_pkg::OP_RELEASE: step = svfenv_pkg::STEP_REL;
                  default: step = svfenv_pkg::STEP_NONE;
               endcase
            end
         end
         S_ENV: begin
            step     = svfenv_pkg::STEP_ENV;
            state_in = S_MOD;
         end
         S_MOD: begin
            step     = svfenv_pkg::STEP_MOD;
            state_in = S_FC;
         end
         S_FC: begin
            step     = svfenv_pkg::STEP_FC;
            state_in = S_PHW;
         end
         S_PHW: begin
            if (!stat.div_busy) begin
               step     = svfenv_pkg::STEP_PH;
               state_in = S_Y;
            end
         end
         S_Y: begin
            step     = svfenv_pkg::STEP_Y;
            state_in = S_Y2;
         end
         S_Y2: begin
            step     = svfenv_pkg::STEP_Y2;
            state_in = S_Y2S;
         end
         S_Y2S: begin
            step     = svfenv_pkg::STEP_Y2S;
            iter_in  = '0;
            state_in = S_TA;
         end
         S_TA: begin
            step     = svfenv_pkg::STEP_TA;
            state_in = S_TB;
         end
         S_TB: begin
            step     = svfenv_pkg::STEP_TB;
            state_in = S_TC;
         end
         S_TC: begin
            step     = svfenv_pkg::STEP_TC;
            state_in = S_TD;
         end
         S_TD: begin
            step = svfenv_pkg::STEP_TD;
            if (iter_ff == ITER_LAST) begin
               state_in = S_SIN;
            end else begin
               iter_in  = iter_ff + 1'b1;
               state_in = S_TA;
            end
         end
         S_SIN: begin
            step     = svfenv_pkg::STEP_SIN;
            state_in = S_SF;
         end
         S_SF: begin
            step     = svfenv_pkg::STEP_SF;
            state_in = S_QW;
         end
         S_QW: begin
            if (!stat.div_busy) begin
               step     = svfenv_pkg::STEP_HP;
               state_in = S_HPS;
            end
         end
         S_HPS: begin
            step     = svfenv_pkg::STEP_HPS;
            state_in = S_BP;
         end
         S_BP: begin
            step     = svfenv_pkg::STEP_BP;
            state_in = S_BPS;
         end
         S_BPS: begin
            step     = svfenv_pkg::STEP_BPS;
            state_in = S_LP;
         end
         S_LP: begin
            step     = svfenv_pkg::STEP_LP;
            state_in = S_LPS;
         end
         S_LPS: begin
            if (!stat.out_busy) begin
               step     = svfenv_pkg::STEP_LPS;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign cmd.step   = step;
   assign cmd.iter   = iter_ff;

endmodule

>>> src/svfenv_dp.sv
// Datapath: configuration, envelope, cutoff, sine polynomial and filter update.
`timescale 1ns / 1ps

module svfenv_dp #(
   parameter int SAMPLE_RATE = svfenv_pkg::SAMPLE_RATE_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  svfenv_pkg::svfenv_cmd_type  cmd,
   output svfenv_pkg::svfenv_stat_type stat,
   input  logic [23:0]                 sample_in,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [23:0]                 csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [23:0]                 rsp_tdata
);

   localparam int RC_W  = 16;
   localparam int SR_W  = $clog2(SAMPLE_RATE + 1);
   localparam int DVS_W = (SR_W > RC_W) ? SR_W : RC_W;

   // Register indexes.
   localparam logic [2:0] R_MODE = 3'd0;
   localparam logic [2:0] R_BASE = 3'd1;
   localparam logic [2:0] R_RES  = 3'd2;
   localparam logic [2:0] R_DEPTH = 3'd3;
   localparam logic [2:0] R_ATT  = 3'd4;
   localparam logic [2:0] R_DEC  = 3'd5;
   localparam logic [2:0] R_SUS  = 3'd6;
   localparam logic [2:0] R_REL  = 3'd7;

   // Envelope stages.
   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_ATTACK  = 3'd1;
   localparam logic [2:0] ST_DECAY   = 3'd2;
   localparam logic [2:0] ST_SUSTAIN = 3'd3;
   localparam logic [2:0] ST_RELEASE = 3'd4;

   // Output selections.
   localparam logic [1:0] MODE_LP = 2'd0;
   localparam logic [1:0] MODE_HP = 2'd1;
   localparam logic [1:0] MODE_BP = 2'd2;

   localparam logic [23:0] ONE_Q23   = 24'd8388608;
   localparam logic [30:0] ONE_Q30   = 31'd1073741824;
   localparam logic [33:0] PI_Q30    = 34'd3373259426;
   localparam logic [29:0] F_MAX_Q30 = 30'd966367641;
   localparam logic signed [41:0] FC_MIN = 42'sd1310720;
   localparam logic signed [41:0] FC_MAX = 42'sd1310720000;
   localparam logic [16:0] RES_MIN   = 17'd410;
   localparam logic [16:0] RES_MAX   = 17'd40960;
   localparam logic signed [27:0] LIM_HI = 28'sd4194304;
   localparam logic signed [27:0] LIM_LO = -28'sd4194304;

   // Configuration registers.
   logic [1:0]         mode_ff;
   logic [14:0]        base_ff;
   logic [16:0]        res_ff;
   logic signed [15:0] depth_ff;
   logic [23:0]        att_ff, dec_ff, sus_ff, rel_ff;

   // Filter and envelope state.
   logic signed [23:0] lp_ff, bp_ff;
   logic [23:0]        lvl_ff, lvl_in;
   logic [2:0]         stage_ff, stage_in;

   // Working registers of one sample.
   logic signed [23:0] x_ff;
   logic signed [67:0] prod_ff, prod_in;
   logic [23:0]        xs_ff;
   logic               fzero_ff;
   logic [30:0]        y_ff, t_ff;
   logic [31:0]        y2_ff, v_ff;
   logic [29:0]        q0_ff, f_ff;
   logic signed [27:0] hp_ff, bpn_ff;
   logic [23:0]        out_ff;
   logic               out_valid_ff;

   // Shared multiplier operands.
   logic signed [33:0] mul_a, mul_b;

   // Combinational helpers.
   logic [23:0]        sus_eff;
   logic [24:0]        atk_sum;
   logic signed [25:0] dec_dif, rel_dif;
   logic signed [41:0] fc_sum;
   logic [30:0]        fc_clip;
   logic [24:0]        ph;
   logic [23:0]        ph_fold;
   logic [16:0]        res_clip;
   logic               dv_start;
   logic [svfenv_pkg::DVD_W-1:0] dv_dividend, dv_quot;
   logic [DVS_W-1:0]   dv_divisor;
   logic               dv_busy;
   logic [31:0]        rem_r;
   logic [30:0]        q_corr;
   logic [32:0]        sine2;
   logic [29:0]        f_new;
   logic signed [27:0] hp_new, bpn_new, lpn_new;
   logic signed [23:0] lp_c, bp_c, hp_c, y_sel;
   logic signed [27:0] notch;
   logic [6:0]         tdiv;

   // Saturate to plus or minus 4.0 in Q3.20.
   function automatic logic signed [23:0] sat4(input logic signed [27:0] v);
      if (v > LIM_HI) begin
         sat4 = LIM_HI[23:0];
      end else if (v < LIM_LO) begin
         sat4 = LIM_LO[23:0];
      end else begin
         sat4 = v[23:0];
      end
   endfunction

   // Envelope step on the current stage.
   always_comb begin
      sus_eff  = (sus_ff > ONE_Q23) ? ONE_Q23 : sus_ff;
      atk_sum  = {1'b0, lvl_ff} + {1'b0, att_ff};
      dec_dif  = $signed({2'b00, lvl_ff}) - $signed({2'b00, dec_ff});
      rel_dif  = $signed({2'b00, lvl_ff}) - $signed({2'b00, rel_ff});
      lvl_in   = lvl_ff;
      stage_in = stage_ff;
      case (stage_ff)
         ST_ATTACK: begin
            if (atk_sum >= {1'b0, ONE_Q23}) begin
               lvl_in   = ONE_Q23;
               stage_in = ST_DECAY;
            end else begin
               lvl_in = atk_sum[23:0];
            end
         end
         ST_DECAY: begin
            if (dec_dif <= $signed({2'b00, sus_eff})) begin
               lvl_in   = sus_eff;
               stage_in = ST_SUSTAIN;
            end else begin
               lvl_in = dec_dif[23:0];
            end
         end
         ST_RELEASE: begin
            if (rel_dif <= 26'sd0) begin
               lvl_in   = '0;
               stage_in = ST_IDLE;
            end else begin
               lvl_in = rel_dif[23:0];
            end
         end
         default: lvl_in = lvl_ff;
      endcase
   end

   // Cutoff in Q16 Hz with modulation, then the phase and resonance divides.
   always_comb begin
      fc_sum = $signed({prod_ff[59], prod_ff[59:19]})
             + $signed({11'b0, base_ff, 16'b0});
      if (fc_sum < FC_MIN) begin
         fc_clip = FC_MIN[30:0];
      end else if (fc_sum > FC_MAX) begin
         fc_clip = FC_MAX[30:0];
      end else begin
         fc_clip = fc_sum[30:0];
      end
      ph      = dv_quot[24:0];
      ph_fold = (ph[23:0] > 24'h800000) ? 24'(25'h1000000 - {1'b0, ph[23:0]}) : ph[23:0];
      if (res_ff < RES_MIN) begin
         res_clip = RES_MIN;
      end else if (res_ff > RES_MAX) begin
         res_clip = RES_MAX;
      end else begin
         res_clip = res_ff;
      end
      dv_start    = 1'b0;
      dv_dividend = {1'b0, fc_clip, 8'b0};
      dv_divisor  = DVS_W'(SAMPLE_RATE);
      if (cmd.step == svfenv_pkg::STEP_FC) begin
         dv_start = 1'b1;
      end else if (cmd.step == svfenv_pkg::STEP_PH) begin
         dv_start    = 1'b1;
         dv_dividend = (svfenv_pkg::DVD_W'(1) << 32)
                     + svfenv_pkg::DVD_W'(res_clip[RC_W-1:1]);
         dv_divisor  = DVS_W'(res_clip[RC_W-1:0]);
      end
   end

   svfenv_div #(
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .dividend (dv_dividend),
      .divisor  (dv_divisor),
      .busy     (dv_busy),
      .quotient (dv_quot)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.step)
         svfenv_pkg::STEP_ENV: begin
            mul_a = 34'(depth_ff);
            mul_b = 34'sd10000;
         end
         svfenv_pkg::STEP_MOD: begin
            mul_a = prod_ff[33:0];
            mul_b = $signed({10'b0, lvl_ff});
         end
         svfenv_pkg::STEP_Y: begin
            mul_a = $signed(PI_Q30);
            mul_b = $signed({10'b0, xs_ff});
         end
         svfenv_pkg::STEP_Y2: begin
            mul_a = $signed({3'b0, prod_ff[54:24]});
            mul_b = $signed({3'b0, prod_ff[54:24]});
         end
         svfenv_pkg::STEP_TA: begin
            mul_a = $signed({2'b0, y2_ff});
            mul_b = $signed({3'b0, t_ff});
         end
         svfenv_pkg::STEP_TB: begin
            mul_a = $signed({2'b0, prod_ff[61:30]});
            mul_b = $signed({4'b0, svfenv_pkg::TAYLOR_RECIP[cmd.iter]});
         end
         svfenv_pkg::STEP_TC: begin
            mul_a = $signed({4'b0, prod_ff[61:32]});
            mul_b = $signed({27'b0, svfenv_pkg::TAYLOR_DIV[cmd.iter]});
         end
         svfenv_pkg::STEP_SIN: begin
            mul_a = $signed({3'b0, y_ff});
            mul_b = $signed({3'b0, t_ff});
         end
         svfenv_pkg::STEP_HP: begin
            mul_a = $signed({10'b0, dv_quot[23:0]});
            mul_b = 34'(bp_ff);
         end
         svfenv_pkg::STEP_BP: begin
            mul_a = $signed({4'b0, f_ff});
            mul_b = 34'(hp_ff);
         end
         svfenv_pkg::STEP_LP: begin
            mul_a = $signed({4'b0, f_ff});
            mul_b = 34'(bpn_ff);
         end
         default: mul_a = '0;
      endcase
      prod_in = mul_a * mul_b;
   end

   // Sine term correction, f and the filter sums.
   always_comb begin
      tdiv    = svfenv_pkg::TAYLOR_DIV[cmd.iter];
      rem_r   = v_ff - prod_ff[31:0];
      q_corr  = {1'b0, q0_ff} + ((rem_r >= {25'b0, tdiv}) ? 31'd1 : 31'd0);
      sine2   = {prod_ff[61:30], 1'b0};
      if (fzero_ff) begin
         f_new = '0;
      end else if (sine2 > {3'b0, F_MAX_Q30}) begin
         f_new = F_MAX_Q30;
      end else begin
         f_new = sine2[29:0];
      end
      hp_new  = 28'(x_ff) - 28'(lp_ff) - prod_ff[47:20];
      bpn_new = 28'(bp_ff) + prod_ff[57:30];
      lpn_new = 28'(lp_ff) + prod_ff[57:30];
      lp_c    = sat4(lpn_new);
      bp_c    = sat4(bpn_ff);
      hp_c    = sat4(hp_ff);
      notch   = 28'(lp_c) + 28'(hp_c);
      case (mode_ff)
         MODE_LP: y_sel = lp_c;
         MODE_HP: y_sel = hp_c;
         MODE_BP: y_sel = bp_c;
         default: y_sel = sat4(notch);
      endcase
   end

   // Configuration, filter state, envelope and output handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 2'd0;
         base_ff      <= 15'd1000;
         res_ff       <= 17'd2896;
         depth_ff     <= '0;
         att_ff       <= 24'd174763;
         dec_ff       <= 24'd174763;
         sus_ff       <= 24'd5872026;
         rel_ff       <= 24'd174763;
         lp_ff        <= '0;
         bp_ff        <= '0;
         lvl_ff       <= '0;
         stage_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               R_MODE:  mode_ff  <= csr_wdata[1:0];
               R_BASE:  base_ff  <= csr_wdata[14:0];
               R_RES:   res_ff   <= csr_wdata[16:0];
               R_DEPTH: depth_ff <= $signed(csr_wdata[15:0]);
               R_ATT:   att_ff   <= csr_wdata;
               R_DEC:   dec_ff   <= csr_wdata;
               R_SUS:   sus_ff   <= csr_wdata;
               R_REL:   rel_ff   <= csr_wdata;
               default: mode_ff  <= mode_ff;
            endcase
         end
         case (cmd.step)
            svfenv_pkg::STEP_TRIG: stage_ff <= ST_ATTACK;
            svfenv_pkg::STEP_REL:  stage_ff <= ST_RELEASE;
            svfenv_pkg::STEP_ENV: begin
               lvl_ff   <= lvl_in;
               stage_ff <= stage_in;
            end
            svfenv_pkg::STEP_LPS: begin
               lp_ff <= lp_c;
               bp_ff <= bp_c;
            end
            default: stage_ff <= stage_ff;
         endcase
         if (cmd.step == svfenv_pkg::STEP_LPS) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers of the sample in flight.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      case (cmd.step)
         svfenv_pkg::STEP_LOAD: x_ff <= $signed(sample_in);
         svfenv_pkg::STEP_PH: begin
            xs_ff    <= ph_fold;
            fzero_ff <= ph[24];
         end
         svfenv_pkg::STEP_Y2: begin
            y_ff <= prod_ff[54:24];
            t_ff <= ONE_Q30;
         end
         svfenv_pkg::STEP_Y2S: y2_ff  <= prod_ff[61:30];
         svfenv_pkg::STEP_TB:  v_ff   <= prod_ff[61:30];
         svfenv_pkg::STEP_TC:  q0_ff  <= prod_ff[61:32];
         svfenv_pkg::STEP_TD:  t_ff   <= ONE_Q30 - q_corr;
         svfenv_pkg::STEP_SF:  f_ff   <= f_new;
         svfenv_pkg::STEP_HPS: hp_ff  <= hp_new;
         svfenv_pkg::STEP_BPS: bpn_ff <= bpn_new;
         svfenv_pkg::STEP_LPS: out_ff <= y_sel;
         default: x_ff <= x_ff;
      endcase
   end

   assign stat.div_busy = dv_busy;
   assign stat.out_busy = out_valid_ff & ~rsp_tready;
   assign rsp_tvalid    = out_valid_ff;
   assign rsp_tdata     = out_ff;

endmodule

>>> bench/tb_state_variable_filter_with_envelope_unit.sv
// Self-checking testbench of the state-variable filter with envelope-modulated cutoff.
`timescale 1ns / 1ps

module tb_state_variable_filter_with_envelope_unit;
   import svfenv_pkg::*;

   // Operation code that the block ignores.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_CUTOFF  = 3'd1;
   localparam logic [2:0] REG_RES     = 3'd2;
   localparam logic [2:0] REG_DEPTH   = 3'd3;
   localparam logic [2:0] REG_ATTACK  = 3'd4;
   localparam logic [2:0] REG_DECAY   = 3'd5;
   localparam logic [2:0] REG_SUSTAIN = 3'd6;
   localparam logic [2:0] REG_RELEASE = 3'd7;

   localparam int PHASES = 8;
   localparam int BEATS_PER_PHASE = 110;
   localparam int SETTLE_CYCLES = 80;
   localparam int STALL_LIMIT = 3000;

   localparam longint ONE_Q23 = 64'sd8388608;
   localparam longint unsigned ONE_Q30 = 64'd1073741824;
   localparam longint unsigned PI_Q30 = 64'd3373259426;
   localparam longint F_MAX = 64'sd966367641;
   localparam longint LIM4 = 64'sd4194304;

   typedef enum int {ENV_IDLE, ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE} env_stage_e;

   typedef struct {
      logic [1:0]  op;
      logic [23:0] sample;
      bit          known;
      logic [23:0] out_val;
   } stim_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_SAMPLE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_wdata = '0;

   // Table value that travels along with the current beat.
   bit          beat_known = 1'b0;
   logic [23:0] beat_out_val = '0;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int errors = 0;
   int stall_cycles = 0;
   logic [23:0] filtered_q[$];

   // Predictor copy of registers and state.
   logic [1:0]  m_mode;
   logic [14:0] m_cutoff;
   logic [16:0] m_res;
   logic signed [15:0] m_depth;
   logic [23:0] m_attack, m_decay, m_sustain, m_release;
   longint m_lp, m_bp, m_level;
   env_stage_e m_stage;

   state_variable_filter_with_envelope_unit u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Receiver readiness, random per cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void reset_model();
      m_mode = 2'd0; m_cutoff = 15'd1000; m_res = 17'd2896; m_depth = '0;
      m_attack = 24'd174763; m_decay = 24'd174763; m_sustain = 24'd5872026;
      m_release = 24'd174763;
      m_lp = 0; m_bp = 0; m_level = 0; m_stage = ENV_IDLE;
   endfunction

   function automatic void model_write(logic [2:0] idx, logic [23:0] v);
      case (idx)
         REG_MODE:    m_mode = v[1:0];
         REG_CUTOFF:  m_cutoff = v[14:0];
         REG_RES:     m_res = v[16:0];
         REG_DEPTH:   m_depth = v[15:0];
         REG_ATTACK:  m_attack = v;
         REG_DECAY:   m_decay = v;
         REG_SUSTAIN: m_sustain = v;
         default:     m_release = v;
      endcase
   endfunction

   // sin(pi*x) in Q30 for x in Q24 within 0..0.5, Horner form.
   function automatic longint unsigned half_turn_sine(longint unsigned x);
      longint unsigned y, y2, t;
      int divisors[5];
      divisors = '{110, 72, 42, 20, 6};
      y = (PI_Q30 * x) >> 24;
      y2 = (y * y) >> 30;
      t = ONE_Q30;
      for (int i = 0; i < 5; i++) t = ONE_Q30 - ((y2 * t) >> 30) / divisors[i];
      return (y * t) >> 30;
   endfunction

   // Advances the envelope and the filter by one audio sample; returns the output.
   function automatic logic [23:0] filter_sample(logic [23:0] raw);
      longint x, sus, fc, f, q, hp, bp, lp, y;
      longint unsigned ph, r;
      x = longint'($signed(raw));
      sus = (longint'(m_sustain) > ONE_Q23) ? ONE_Q23 : longint'(m_sustain);
      case (m_stage)
         ENV_ATTACK: begin
            m_level += longint'(m_attack);
            if (m_level >= ONE_Q23) begin
               m_level = ONE_Q23; m_stage = ENV_DECAY;
            end
         end
         ENV_DECAY: begin
            m_level -= longint'(m_decay);
            if (m_level <= sus) begin
               m_level = sus; m_stage = ENV_SUSTAIN;
            end
         end
         ENV_RELEASE: begin
            m_level -= longint'(m_release);
            if (m_level <= 0) begin
               m_level = 0; m_stage = ENV_IDLE;
            end
         end
         default: ;
      endcase
      fc = (longint'(m_cutoff) <<< 16) + ((longint'(m_depth) * m_level * 10000) >>> 19);
      fc = clamp(fc, 64'sd20 <<< 16, 64'sd20000 <<< 16);
      ph = ((longint'(fc) << 8) / SAMPLE_RATE_DEF) & ((64'd1 << 25) - 1);
      if (ph >= (64'd1 << 24)) begin
         f = 0;
      end else begin
         if (ph > (64'd1 << 23)) ph = (64'd1 << 24) - ph;
         f = longint'(2 * half_turn_sine(ph));
         if (f > F_MAX) f = F_MAX;
      end
      r = m_res;
      if (r < 410) r = 410;
      if (r > 40960) r = 40960;
      q = longint'(((64'd1 << 32) + r / 2) / r);
      hp = x - m_lp - ((q * m_bp) >>> 20);
      bp = m_bp + ((f * hp) >>> 30);
      lp = m_lp + ((f * bp) >>> 30);
      m_lp = clamp(lp, -LIM4, LIM4);
      m_bp = clamp(bp, -LIM4, LIM4);
      hp = clamp(hp, -LIM4, LIM4);
      case (m_mode)
         2'd0:    y = m_lp;
         2'd1:    y = hp;
         2'd2:    y = m_bp;
         default: y = m_lp + hp;
      endcase
      return 24'(clamp(y, -LIM4, LIM4));
   endfunction

   // Prediction on accepted request beats, checking on accepted result beats.
   always @(posedge clock) begin
      logic [23:0] want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               OP_SAMPLE: begin
                  want = filter_sample(req_tdata);
                  if (beat_known && want !== beat_out_val) begin
                     $display("%0t: table mismatch: expected %h, predicted %h",
                              $time, beat_out_val, want);
                     errors++;
                  end
                  filtered_q.push_back(want);
               end
               OP_TRIGGER: m_stage = ENV_ATTACK;
               OP_RELEASE: m_stage = ENV_RELEASE;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (filtered_q.size() == 0) begin
               $display("%0t: unexpected result beat: expected none, actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = filtered_q.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: sample_out mismatch: expected %h, actual %h",
                           $time, want, rsp_tdata);
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] op, logic [23:0] sample, bit known,
                            logic [23:0] out_val);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= sample;
      beat_known <= known;
      beat_out_val <= out_val;
      do @(posedge clock); while (!req_tready);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   // Holds the sender until every expected result has come, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (filtered_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [23:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      model_write(idx, v);
   endtask

   task automatic configure(int phase);
      logic [23:0] v[8];
      case (phase)
         1: v = '{24'd0, 24'd20, 24'd0, 24'hFFC000, 24'd8388608, 24'd8388608, 24'd0,
                  24'd8388608};
         2: v = '{24'd1, 24'd20000, 24'h1FFFF, 24'h004000, 24'd1, 24'd1, 24'hFFFFFF,
                  24'd1};
         3: v = '{24'd2, 24'd1000, 24'd410, 24'h004000, 24'd0, 24'd0, 24'd4194304,
                  24'd0};
         4: v = '{24'd3, 24'd20000, 24'd81920, 24'hFFC000, 24'd600000, 24'd300000,
                  24'd2000000, 24'd400000};
         default: begin
            v[0] = $urandom_range(3);
            v[1] = $urandom_range(20000, 20);
            v[2] = $urandom_range(81920, 410);
            v[3] = 24'($signed(16'($urandom_range(32768)) - 16'sd16384));
            v[4] = $urandom_range(2000000, 1);
            v[5] = $urandom_range(2000000, 1);
            v[6] = $urandom_range(8388608);
            v[7] = $urandom_range(2000000, 1);
         end
      endcase
      for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
      csr_we <= 1'b0;
   endtask

   // Stimulus.
   initial begin
      stim_row_t rows[$];
      int pick;
      logic [1:0] op;
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part at reset settings.
      tx_idle_pct = 8;
      rx_idle_pct = 50;
      rows = '{
         '{OP_SAMPLE, 24'h000000, 1'b1, 24'h000000},
         '{OP_UNUSED, 24'hFFFFFF, 1'b0, 24'h0},
         '{OP_RELEASE, 24'h000000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h000000, 1'b1, 24'h000000},
         '{OP_SAMPLE, 24'h7FFFFF, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h800000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h7FFFFF, 1'b0, 24'h0},
         '{OP_TRIGGER, 24'h000000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h100000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'hF00000, 1'b0, 24'h0},
         '{OP_TRIGGER, 24'h555555, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h555555, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'hAAAAAA, 1'b0, 24'h0},
         '{OP_RELEASE, 24'h000000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h000001, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'hFFFFFF, 1'b0, 24'h0},
         '{OP_UNUSED, 24'h000000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'h400000, 1'b0, 24'h0},
         '{OP_SAMPLE, 24'hC00000, 1'b0, 24'h0}};
      foreach (rows[i]) send_beat(rows[i].op, rows[i].sample, rows[i].known, rows[i].out_val);

      // Random part, one register setting per phase.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase > 0) configure(phase);
         if (phase < 3) begin
            tx_idle_pct = 8; rx_idle_pct = 50;
         end else if (phase < 6) begin
            tx_idle_pct = 50; rx_idle_pct = 8;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         for (int n = 0; n < BEATS_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            op = pick < 82 ? OP_SAMPLE : pick < 91 ? OP_TRIGGER : pick < 98 ? OP_RELEASE
                 : OP_UNUSED;
            send_beat(op, 24'($urandom), 1'b0, 24'h0);
         end
      end

      drain();
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> sim.f
src/svfenv_pkg.sv
src/svfenv_div.sv
src/svfenv_ctrl.sv
src/svfenv_dp.sv
src/state_variable_filter_with_envelope_unit.sv
bench/tb_state_variable_filter_with_envelope_unit.sv
